/* hdl/fcwa_pkg.sv */
// Package with the flow cache types, sizes and register codes.
`timescale 1ns / 1ps
package fcwa_pkg;

   localparam int CACHE_ENTRIES = 64;
   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam int LIM_W = 7;
   localparam int TMO_W = 22;
   localparam int CSR_W = 12;
   localparam logic [9:0] MS_PER_S = 10'd1000;

   localparam logic [1:0] REG_ACTIVE = 2'd0;
   localparam logic [1:0] REG_INACTIVE = 2'd1;
   localparam logic [1:0] REG_LIMIT = 2'd2;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  proto;
      logic [7:0]  tos;
      logic [7:0]  flags;
      logic [31:0] packets;
      logic [31:0] bytes;
      logic [31:0] first_ms;
      logic [31:0] last_ms;
   } flow_type;

   typedef struct packed {
      logic     valid;
      flow_type flow;
   } entry_type;

   typedef struct packed {
      logic push;
      logic finish;
   } out_cmd_type;

   typedef struct packed {
      logic can_push;
      logic can_finish;
   } out_sts_type;

endpackage

/* hdl/fcwa_cell.sv */
// One cache cell of the rotating entry ring.
`timescale 1ns / 1ps
module fcwa_cell import fcwa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type entry_in,
   output entry_type entry_out
);

   logic     valid_ff;
   flow_type flow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         flow_ff <= entry_in.flow;
      end
   end

   assign entry_out = '{valid: valid_ff, flow: flow_ff};

endmodule

/* hdl/fcwa_out.sv */
// Pending export stage and output register of the flow cache.
`timescale 1ns / 1ps
module fcwa_out import fcwa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  out_cmd_type cmd,
   input  flow_type    flow_new,
   output out_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output flow_type    rsp_flow,
   output logic        rsp_eor
);

   logic     pend_v_ff, pend_v_in;
   flow_type pend_ff;
   logic     out_v_ff, out_v_in;
   flow_type out_ff;
   logic     eor_ff;
   logic     out_free;
   logic     do_push, do_finish;

   assign out_free = !out_v_ff || rsp_ready;
   assign sts.can_push = !pend_v_ff || out_free;
   assign sts.can_finish = !pend_v_ff || out_free;
   assign do_push = cmd.push && sts.can_push;
   assign do_finish = cmd.finish && pend_v_ff && out_free;

   always_comb begin
      pend_v_in = pend_v_ff;
      out_v_in = out_v_ff && !rsp_ready;
      if (do_push) begin
         pend_v_in = 1'b1;
         if (pend_v_ff) begin
            out_v_in = 1'b1;
         end
      end else if (do_finish) begin
         pend_v_in = 1'b0;
         out_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         pend_ff <= flow_new;
         if (pend_v_ff) begin
            out_ff <= pend_ff;
            eor_ff <= 1'b0;
         end
      end else if (do_finish) begin
         out_ff <= pend_ff;
         eor_ff <= 1'b1;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_flow = out_ff;
   assign rsp_eor = eor_ff;

endmodule

/* hdl/flow_cache_with_aging.sv */
// Top level of the flow cache: entry ring, sweep control and configuration.
// Flow: a packet runs a sweep pass and an update pass of the entry ring, then a drain step,
// each of which output stalls can hold; a flush runs a sweep pass and then the drain step.
// A new request is taken only in idle, so the ring finishes one request before the next.
// Reset: synchronous; empties the cache and loads timeouts 60 s / 10 s and limit 64.
`timescale 1ns / 1ps
module flow_cache_with_aging import fcwa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_time_ms,
   input  logic [31:0] req_source_ip,
   input  logic [31:0] req_dest_ip,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [7:0]  req_ip_protocol,
   input  logic [7:0]  req_type_of_service,
   input  logic [7:0]  req_tcp_flag_bits,
   input  logic [15:0] req_packet_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [CSR_W-1:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_flow_source_ip,
   output logic [31:0] rsp_flow_dest_ip,
   output logic [15:0] rsp_flow_source_port,
   output logic [15:0] rsp_flow_dest_port,
   output logic [7:0]  rsp_flow_protocol,
   output logic [7:0]  rsp_flow_tos,
   output logic [7:0]  rsp_flow_flags,
   output logic [31:0] rsp_flow_packets,
   output logic [31:0] rsp_flow_bytes,
   output logic [31:0] rsp_flow_first_ms,
   output logic [31:0] rsp_flow_last_ms,
   output logic        rsp_end_of_run
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_APPLY = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [TMO_W-1:0] act_ff, ina_ff;
   logic [LIM_W-1:0] lim_ff;
   logic [TMO_W-1:0] tmo_in;

   logic        kind_ff;
   flow_type    req_ff;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             hit_f_ff, hit_f_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic             free_f_ff, free_f_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic             old_f_ff, old_f_in;
   logic [IDX_W-1:0] old_ff, old_in;
   logic [31:0]      oldt_ff, oldt_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             evict_ff, evict_in;
   logic             slot_f_ff, slot_f_in;
   logic [IDX_W-1:0] slot_ff, slot_in;

   entry_type ring [CACHE_ENTRIES];
   entry_type head, tail_in;
   logic      step, emit, survivor, key_hit, expired, last_idx;
   logic [31:0] age, idle;
   logic [32:0] bsum;
   logic [LIM_W-1:0] lim_eff;
   out_cmd_type ocmd;
   out_sts_type osts;
   flow_type    oflow;

   assign csr_ready = 1'b1;
   assign tmo_in = TMO_W'({10'd0, csr_data} * {12'd0, MS_PER_S});

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= TMO_W'(60 * 1000);
         ina_ff <= TMO_W'(10 * 1000);
         lim_ff <= LIM_W'(64);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ACTIVE:   act_ff <= tmo_in;
            REG_INACTIVE: ina_ff <= tmo_in;
            REG_LIMIT:    lim_ff <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         req_ff.src_ip <= req_source_ip;
         req_ff.dst_ip <= req_dest_ip;
         req_ff.src_port <= req_source_port;
         req_ff.dst_port <= req_dest_port;
         req_ff.proto <= req_ip_protocol;
         req_ff.tos <= req_type_of_service;
         req_ff.flags <= req_tcp_flag_bits;
         req_ff.packets <= 32'd1;
         req_ff.bytes <= {16'd0, req_packet_bytes};
         req_ff.first_ms <= req_time_ms;
         req_ff.last_ms <= req_time_ms;
      end
   end

   assign head = ring[0];
   assign last_idx = (idx_ff == IDX_W'(CACHE_ENTRIES - 1));
   assign age = head.flow.last_ms - head.flow.first_ms;
   assign idle = req_ff.last_ms - head.flow.last_ms;
   assign key_hit = head.flow.src_ip == req_ff.src_ip && head.flow.dst_ip == req_ff.dst_ip
      && head.flow.src_port == req_ff.src_port && head.flow.dst_port == req_ff.dst_port
      && head.flow.proto == req_ff.proto;
   assign expired = kind_ff || age >= {10'd0, act_ff}
      || (req_ff.last_ms >= head.flow.last_ms && idle >= {10'd0, ina_ff});
   assign bsum = {1'b0, head.flow.bytes} + {1'b0, req_ff.bytes};
   assign lim_eff = (lim_ff == '0) ? LIM_W'(1)
      : (lim_ff > LIM_W'(CACHE_ENTRIES)) ? LIM_W'(CACHE_ENTRIES) : lim_ff;

   always_comb begin
      emit = 1'b0;
      tail_in = head;
      if (state_ff == ST_SWEEP) begin
         emit = head.valid && expired;
         if (emit) begin
            tail_in.valid = 1'b0;
         end
      end else if (state_ff == ST_APPLY) begin
         if (hit_f_ff && idx_ff == hit_ff) begin
            tail_in.flow.last_ms = req_ff.last_ms;
            if (head.flow.packets != '1) begin
               tail_in.flow.packets = head.flow.packets + 32'd1;
            end
            tail_in.flow.flags = head.flow.flags | req_ff.flags;
            tail_in.flow.bytes = bsum[32] ? '1 : bsum[31:0];
         end
         if (evict_ff && idx_ff == old_ff) begin
            emit = 1'b1;
            tail_in.valid = 1'b0;
         end
         if (slot_f_ff && idx_ff == slot_ff) begin
            tail_in.valid = 1'b1;
            tail_in.flow = req_ff;
         end
      end
   end

   assign survivor = head.valid && !emit;
   assign step = (state_ff == ST_SWEEP || state_ff == ST_APPLY) && (!emit || osts.can_push);
   assign ocmd.push = emit && step;
   assign ocmd.finish = (state_ff == ST_DRAIN);
   assign oflow = head.flow;

   for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_ring
      if (k == CACHE_ENTRIES - 1) begin : g_tail
         fcwa_cell u_cell (
            .clock(clock), .reset(reset), .shift(step),
            .entry_in(tail_in), .entry_out(ring[k])
         );
      end else begin : g_body
         fcwa_cell u_cell (
            .clock(clock), .reset(reset), .shift(step),
            .entry_in(ring[k+1]), .entry_out(ring[k])
         );
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      hit_f_in = hit_f_ff;
      hit_in = hit_ff;
      free_f_in = free_f_ff;
      free_in = free_ff;
      old_f_in = old_f_ff;
      old_in = old_ff;
      oldt_in = oldt_ff;
      cnt_in = cnt_ff;
      evict_in = evict_ff;
      slot_f_in = slot_f_ff;
      slot_in = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SWEEP;
               idx_in = '0;
               hit_f_in = 1'b0;
               free_f_in = 1'b0;
               old_f_in = 1'b0;
               cnt_in = '0;
            end
         end
         ST_SWEEP: begin
            if (step) begin
               idx_in = idx_ff + IDX_W'(1);
               if (survivor) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (key_hit && !hit_f_ff) begin
                     hit_f_in = 1'b1;
                     hit_in = idx_ff;
                  end
                  if (!old_f_ff || head.flow.first_ms <= oldt_ff) begin
                     old_f_in = 1'b1;
                     old_in = idx_ff;
                     oldt_in = head.flow.first_ms;
                  end
               end else if (!free_f_ff) begin
                  free_f_in = 1'b1;
                  free_in = idx_ff;
               end
               if (last_idx) begin
                  state_in = kind_ff ? ST_DRAIN : ST_APPLY;
                  idx_in = '0;
                  evict_in = !hit_f_in && old_f_in && (LIM_W'(cnt_in) >= lim_eff);
                  slot_f_in = !hit_f_in && (free_f_in || evict_in);
                  if (evict_in && (!free_f_in || old_in < free_in)) begin
                     slot_in = old_in;
                  end else begin
                     slot_in = free_in;
                  end
               end
            end
         end
         ST_APPLY: begin
            if (step) begin
               idx_in = idx_ff + IDX_W'(1);
               if (last_idx) begin
                  state_in = ST_DRAIN;
                  idx_in = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (osts.can_finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         hit_f_ff <= 1'b0;
         free_f_ff <= 1'b0;
         old_f_ff <= 1'b0;
         cnt_ff <= '0;
         evict_ff <= 1'b0;
         slot_f_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         hit_f_ff <= hit_f_in;
         free_f_ff <= free_f_in;
         old_f_ff <= old_f_in;
         cnt_ff <= cnt_in;
         evict_ff <= evict_in;
         slot_f_ff <= slot_f_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      free_ff <= free_in;
      old_ff <= old_in;
      oldt_ff <= oldt_in;
      slot_ff <= slot_in;
   end

   flow_type rsp_flow;

   fcwa_out u_out (
      .clock(clock), .reset(reset), .cmd(ocmd), .flow_new(oflow), .sts(osts),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_flow(rsp_flow),
      .rsp_eor(rsp_end_of_run)
   );

   assign rsp_flow_source_ip = rsp_flow.src_ip;
   assign rsp_flow_dest_ip = rsp_flow.dst_ip;
   assign rsp_flow_source_port = rsp_flow.src_port;
   assign rsp_flow_dest_port = rsp_flow.dst_port;
   assign rsp_flow_protocol = rsp_flow.proto;
   assign rsp_flow_tos = rsp_flow.tos;
   assign rsp_flow_flags = rsp_flow.flags;
   assign rsp_flow_packets = rsp_flow.packets;
   assign rsp_flow_bytes = rsp_flow.bytes;
   assign rsp_flow_first_ms = rsp_flow.first_ms;
   assign rsp_flow_last_ms = rsp_flow.last_ms;

endmodule

/* tb/flow_cache_with_aging_checker.sv */
// Checker for the flow cache: watches all channels, predicts exports and compares them.
`timescale 1ns / 1ps
module flow_cache_with_aging_checker import fcwa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_kind,
   input  logic [31:0]      req_time_ms,
   input  logic [31:0]      req_source_ip,
   input  logic [31:0]      req_dest_ip,
   input  logic [15:0]      req_source_port,
   input  logic [15:0]      req_dest_port,
   input  logic [7:0]       req_ip_protocol,
   input  logic [7:0]       req_type_of_service,
   input  logic [7:0]       req_tcp_flag_bits,
   input  logic [15:0]      req_packet_bytes,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [31:0]      rsp_flow_source_ip,
   input  logic [31:0]      rsp_flow_dest_ip,
   input  logic [15:0]      rsp_flow_source_port,
   input  logic [15:0]      rsp_flow_dest_port,
   input  logic [7:0]       rsp_flow_protocol,
   input  logic [7:0]       rsp_flow_tos,
   input  logic [7:0]       rsp_flow_flags,
   input  logic [31:0]      rsp_flow_packets,
   input  logic [31:0]      rsp_flow_bytes,
   input  logic [31:0]      rsp_flow_first_ms,
   input  logic [31:0]      rsp_flow_last_ms,
   input  logic             rsp_end_of_run,
   output int               fails,
   output int               expected_left
);

   typedef struct {
      flow_type flow;
      logic     last;
   } export_type;

   export_type exports_due[$];
   flow_type   slot_flow[CACHE_ENTRIES];
   logic       slot_used[CACHE_ENTRIES];
   int         occupancy;
   logic [11:0] active_s;
   logic [11:0] inactive_s;
   logic [6:0]  limit_reg;
   int          run_len;

   assign expected_left = exports_due.size();

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
         fails++;
      end
   endtask

   function automatic void export_slot(input int i);
      export_type e;
      e.flow = slot_flow[i];
      e.last = 1'b0;
      exports_due.push_back(e);
      slot_used[i] = 1'b0;
      if (occupancy > 0) occupancy--;
      run_len++;
   endfunction

   function automatic void account_packet();
      logic [31:0] act_ms, ina_ms, now, lim;
      int          hit, oldest, slot;
      flow_type    f;
      act_ms = active_s * 32'd1000;
      ina_ms = inactive_s * 32'd1000;
      now = req_time_ms;
      hit = -1;
      oldest = -1;
      slot = -1;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (slot_used[i]) begin
            if (slot_flow[i].last_ms - slot_flow[i].first_ms >= act_ms) export_slot(i);
            else if (now >= slot_flow[i].last_ms && now - slot_flow[i].last_ms >= ina_ms)
               export_slot(i);
         end
      end
      for (int i = 0; i < CACHE_ENTRIES && hit < 0; i++) begin
         if (slot_used[i] && slot_flow[i].src_ip == req_source_ip &&
             slot_flow[i].dst_ip == req_dest_ip && slot_flow[i].src_port == req_source_port &&
             slot_flow[i].dst_port == req_dest_port && slot_flow[i].proto == req_ip_protocol)
            hit = i;
      end
      if (hit >= 0) begin
         slot_flow[hit].last_ms = now;
         if (slot_flow[hit].packets != 32'hFFFF_FFFF) slot_flow[hit].packets++;
         slot_flow[hit].flags |= req_tcp_flag_bits;
         if (slot_flow[hit].bytes > 32'hFFFF_FFFF - req_packet_bytes)
            slot_flow[hit].bytes = 32'hFFFF_FFFF;
         else
            slot_flow[hit].bytes += req_packet_bytes;
      end else begin
         lim = limit_reg;
         if (lim < 1) lim = 1;
         if (lim > CACHE_ENTRIES) lim = CACHE_ENTRIES;
         if (occupancy >= lim) begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
               if (slot_used[i] && (oldest < 0 ||
                   slot_flow[i].first_ms <= slot_flow[oldest].first_ms)) oldest = i;
            if (oldest >= 0) export_slot(oldest);
         end
         for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
            if (!slot_used[i]) slot = i;
         if (slot >= 0) begin
            f.src_ip = req_source_ip;
            f.dst_ip = req_dest_ip;
            f.src_port = req_source_port;
            f.dst_port = req_dest_port;
            f.proto = req_ip_protocol;
            f.tos = req_type_of_service;
            f.flags = req_tcp_flag_bits;
            f.packets = 32'd1;
            f.bytes = {16'd0, req_packet_bytes};
            f.first_ms = now;
            f.last_ms = now;
            slot_flow[slot] = f;
            slot_used[slot] = 1'b1;
            occupancy++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CACHE_ENTRIES; i++) slot_used[i] = 1'b0;
         occupancy = 0;
         fails = 0;
         active_s = 12'd60;
         inactive_s = 12'd10;
         limit_reg = 7'd64;
         exports_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ACTIVE: active_s = csr_data;
               REG_INACTIVE: inactive_s = csr_data;
               REG_LIMIT: limit_reg = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            run_len = 0;
            if (req_kind) begin
               for (int i = 0; i < CACHE_ENTRIES; i++)
                  if (slot_used[i]) export_slot(i);
            end else begin
               account_packet();
            end
            if (run_len > 0) exports_due[exports_due.size() - 1].last = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (exports_due.size() == 0) begin
               $display("mismatch: unexpected export at %0t", $realtime);
               fails++;
            end else begin
               export_type e;
               e = exports_due.pop_front();
               report("source_ip", rsp_flow_source_ip, e.flow.src_ip);
               report("dest_ip", rsp_flow_dest_ip, e.flow.dst_ip);
               report("source_port", {16'd0, rsp_flow_source_port}, {16'd0, e.flow.src_port});
               report("dest_port", {16'd0, rsp_flow_dest_port}, {16'd0, e.flow.dst_port});
               report("protocol", {24'd0, rsp_flow_protocol}, {24'd0, e.flow.proto});
               report("tos", {24'd0, rsp_flow_tos}, {24'd0, e.flow.tos});
               report("flags", {24'd0, rsp_flow_flags}, {24'd0, e.flow.flags});
               report("packets", rsp_flow_packets, e.flow.packets);
               report("bytes", rsp_flow_bytes, e.flow.bytes);
               report("first_ms", rsp_flow_first_ms, e.flow.first_ms);
               report("last_ms", rsp_flow_last_ms, e.flow.last_ms);
               report("end_of_run", {31'd0, rsp_end_of_run}, {31'd0, e.last});
            end
         end
      end
   end

endmodule

/* tb/flow_cache_with_aging_test.sv */
// Testbench top for the flow cache: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps
module flow_cache_with_aging_test;
   import fcwa_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_kind = 1'b0;
   logic [31:0]      req_time_ms = '0;
   logic [31:0]      req_source_ip = '0;
   logic [31:0]      req_dest_ip = '0;
   logic [15:0]      req_source_port = '0;
   logic [15:0]      req_dest_port = '0;
   logic [7:0]       req_ip_protocol = '0;
   logic [7:0]       req_type_of_service = '0;
   logic [7:0]       req_tcp_flag_bits = '0;
   logic [15:0]      req_packet_bytes = '0;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = REG_ACTIVE;
   logic [CSR_W-1:0] csr_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b1;
   logic [31:0]      rsp_flow_source_ip, rsp_flow_dest_ip;
   logic [15:0]      rsp_flow_source_port, rsp_flow_dest_port;
   logic [7:0]       rsp_flow_protocol, rsp_flow_tos, rsp_flow_flags;
   logic [31:0]      rsp_flow_packets, rsp_flow_bytes, rsp_flow_first_ms, rsp_flow_last_ms;
   logic             rsp_end_of_run;
   int               fails;
   int               expected_left;
   logic             quiet = 1'b0;
   int               stall_left = 0;
   int               idle_cycles = 0;

   logic [31:0] key_sip[12], key_dip[12];
   logic [15:0] key_sport[12], key_dport[12];
   logic [7:0]  key_proto[12];
   logic [31:0] clock_ms;

   flow_cache_with_aging dut (.*);
   flow_cache_with_aging_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || quiet) rsp_ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("** flow_cache_with_aging: FAILED **");
         $finish;
      end
   end

   task automatic send(input logic kind, input logic [31:0] t, input logic [31:0] sip,
                       input logic [31:0] dip, input logic [15:0] sport,
                       input logic [15:0] dport, input logic [7:0] proto,
                       input logic [7:0] tos, input logic [7:0] flags,
                       input logic [15:0] nbytes);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_time_ms <= t;
      req_source_ip <= sip;
      req_dest_ip <= dip;
      req_source_port <= sport;
      req_dest_port <= dport;
      req_ip_protocol <= proto;
      req_type_of_service <= tos;
      req_tcp_flag_bits <= flags;
      req_packet_bytes <= nbytes;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_W-1:0] act, input logic [CSR_W-1:0] ina,
                            input logic [CSR_W-1:0] lim);
      drain();
      write_reg(REG_ACTIVE, act);
      write_reg(REG_INACTIVE, ina);
      write_reg(REG_LIMIT, lim);
   endtask

   task automatic pkt(input int k, input logic [31:0] t);
      send(1'b0, t, key_sip[k], key_dip[k], key_sport[k], key_dport[k], key_proto[k],
           8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic random_phase(input int count);
      int k;
      for (int i = 0; i < 12; i++) begin
         key_sip[i] = $urandom;
         key_dip[i] = $urandom;
         key_sport[i] = 16'($urandom);
         key_dport[i] = 16'($urandom);
         key_proto[i] = 8'($urandom);
      end
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 99)) inside
            [0:2]: clock_ms = clock_ms - $urandom_range(1, 20000);
            [3:4]: clock_ms = $urandom;
            default: clock_ms = clock_ms + $urandom_range(0, 3000);
         endcase
         k = $urandom_range(0, 99);
         if (k < 5)
            send(1'b1, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
         else if (k < 20)
            send(1'b0, clock_ms, $urandom, $urandom, 16'($urandom), 16'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
         else pkt($urandom_range(0, 11), clock_ms);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(1'b0, 100, '1, '1, '1, '1, '1, '1, '1, '1);
      send(1'b0, 200, 0, 0, 0, 0, 0, 8'h5a, 8'h12, 16'd1500);
      send(1'b0, 50, 0, 0, 0, 0, 0, 8'h01, 8'h01, 16'd40);
      send(1'b0, 150, '1, '1, '1, '1, '1, 0, 0, '1);
      send(1'b0, 20000, 32'h0a000001, 32'h0a000002, 16'd80, 16'd443, 8'd6, 0, 8'h02, 64);
      send(1'b0, 50000, 32'h0a000001, 32'h0a000002, 16'd80, 16'd443, 8'd6, 0, 8'h10, 64);
      send(1'b0, 81000, 32'h0a000001, 32'h0a000002, 16'd80, 16'd443, 8'd6, 0, 8'h01, 64);
      send(1'b0, 81500, 32'h0a000001, 32'h0a000002, 16'd80, 16'd443, 8'd6, 0, 8'h01, 64);
      send(1'b0, 32'hFFFF_FFFF, 32'h0a000003, 0, 0, 0, 8'd1, 0, 0, 84);
      send(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      configure(12'd0, 12'd4095, 12'd0);
      send(1'b0, 1000, 1, 2, 3, 4, 8'd17, 0, 0, 100);
      send(1'b0, 1000, 1, 2, 3, 4, 8'd17, 0, 0, 100);
      send(1'b0, 900, 5, 6, 7, 8, 8'd17, 0, 0, 100);
      configure(12'd4095, 12'd0, 12'd1);
      send(1'b0, 2000, 1, 2, 3, 4, 8'd6, 0, 0, 10);
      send(1'b0, 2000, 9, 9, 9, 9, 8'd6, 0, 0, 10);
      configure(12'd4095, 12'd4095, 12'd2);
      send(1'b0, 3000, 1, 1, 1, 1, 8'd6, 0, 0, 10);
      send(1'b0, 3000, 2, 2, 2, 2, 8'd6, 0, 0, 10);
      send(1'b0, 3000, 3, 3, 3, 3, 8'd6, 0, 0, 10);
      send(1'b0, 3000, 4, 4, 4, 4, 8'd6, 0, 0, 10);
      configure(12'd4095, 12'd4095, 12'd127);
      send(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      clock_ms = 0;
      configure(12'd60, 12'd10, 12'd64);
      random_phase(80);
      configure(12'd1, 12'd1, 12'd8);
      random_phase(80);
      configure(12'd4095, 12'd4095, 12'd3);
      random_phase(80);
      configure(12'd2, 12'd5, 12'd127);
      random_phase(80);
      configure(12'($urandom_range(1, 30)), 12'($urandom_range(1, 30)),
                12'($urandom_range(1, 64)));
      quiet <= 1'b1;
      random_phase(80);

      drain();
      repeat (100) @(posedge clock);
      if (fails == 0 && expected_left == 0) $display("** flow_cache_with_aging: PASSED **");
      else $display("** flow_cache_with_aging: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
hdl/fcwa_pkg.sv
hdl/fcwa_cell.sv
hdl/fcwa_out.sv
hdl/flow_cache_with_aging.sv
tb/flow_cache_with_aging_checker.sv
tb/flow_cache_with_aging_test.sv
